>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> hw/rtl/peib_pkg.sv
// ----------------------------------------------------------------------------
// peib_pkg
// Types, constants and datapath functions of the particle integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package peib_pkg;

  localparam int DataW     = 32;
  localparam int CfgW      = 31;
  localparam int DampW     = 17;
  localparam int FracW     = 16;
  localparam int QuoW      = DataW + FracW;
  localparam int DivSteps  = QuoW;
  localparam int TailStages = 12;
  localparam int Depth     = DivSteps + 1 + TailStages;
  localparam int InTdataW  = 224;
  localparam int OutTdataW = 128;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgW-1:0]  TimeStepRst = 31'd1092;
  localparam logic [CfgW-1:0]  WallXRst    = 31'd52428800;
  localparam logic [CfgW-1:0]  WallYRst    = 31'd39321600;
  localparam logic [DampW-1:0] DampRst     = 17'd32768;

  typedef logic signed [DataW-1:0] q_t;

  localparam q_t QMax = 32'sh7FFF_FFFF;
  localparam q_t QMin = 32'sh8000_0000;

  localparam logic signed [QuoW-1:0] ShMax = 48'sd2147483647;
  localparam logic signed [QuoW-1:0] ShMin = -48'sd2147483648;
  localparam logic [QuoW-1:0] PosLim = 48'd2147483647;
  localparam logic [QuoW-1:0] NegLim = 48'd2147483648;

  typedef enum logic [CfgIdxW-1:0] {
    RegTimeStep = 2'd0,
    RegWallX    = 2'd1,
    RegWallY    = 2'd2,
    RegDamping  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    TlAccel   = 4'd0,
    TlMulTmp  = 4'd1,
    TlShTmp   = 4'd2,
    TlAddVel  = 4'd3,
    TlMulVel  = 4'd4,
    TlAddPos  = 4'd5,
    TlWall    = 4'd6,
    TlMulDamp = 4'd7,
    TlBounce1 = 4'd8,
    TlBounce2 = 4'd9
  } tl_op_e;

  localparam tl_op_e TailOp [TailStages] = '{
    TlAccel, TlMulTmp, TlShTmp, TlAddVel, TlMulVel, TlShTmp,
    TlAddPos, TlWall, TlMulDamp, TlBounce1, TlMulDamp, TlBounce2
  };

  // restoring divider state, one axis
  typedef struct packed {
    logic [CfgW-1:0] rem;
    logic [QuoW-1:0] dq;
    logic            neg;
    logic            fz;
    q_t              pos;
    q_t              vel;
  } div_ax_t;

  // post-divide state, one axis
  typedef struct packed {
    q_t                    pos;
    q_t                    vel;
    q_t                    tmp;
    logic signed [63:0]    prod;
    logic                  hit1;
    logic                  hit2;
  } tl_ax_t;

  function automatic div_ax_t div_load(input q_t pos, input q_t vel, input q_t push);
    div_ax_t r;
    logic [DataW-1:0] mag;
    mag   = push[DataW-1] ? DataW'(-push) : DataW'(push);
    r.rem = '0;
    r.dq  = {mag, {FracW{1'b0}}};
    r.neg = push[DataW-1];
    r.fz  = (push == '0);
    r.pos = pos;
    r.vel = vel;
    return r;
  endfunction

  function automatic div_ax_t div_step(input div_ax_t s, input logic [CfgW-1:0] m);
    div_ax_t r;
    logic [CfgW:0] part;
    logic [CfgW:0] diff;
    logic          ge;
    part  = {s.rem, s.dq[QuoW-1]};
    diff  = part - {1'b0, m};
    ge    = (part >= {1'b0, m});
    r     = s;
    r.rem = ge ? diff[CfgW-1:0] : part[CfgW-1:0];
    r.dq  = {s.dq[QuoW-2:0], ge};
    return r;
  endfunction

  function automatic q_t accel_of(input div_ax_t s);
    q_t a;
    if (s.fz) begin
      a = '0;
    end else if (!s.neg) begin
      a = (s.dq > PosLim) ? QMax : q_t'(s.dq[DataW-1:0]);
    end else begin
      a = (s.dq > NegLim) ? QMin : q_t'(-s.dq[DataW-1:0]);
    end
    return a;
  endfunction

  // floor(p / 2^16), saturated
  function automatic q_t sat_shift(input logic signed [63:0] p);
    logic signed [QuoW-1:0] s;
    s = QuoW'(p >>> FracW);
    if (s > ShMax) return QMax;
    if (s < ShMin) return QMin;
    return q_t'(s[DataW-1:0]);
  endfunction

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [DataW:0] s;
    s = (DataW+1)'(a) + (DataW+1)'(b);
    if (s > (DataW+1)'(QMax)) return QMax;
    if (s < (DataW+1)'(QMin)) return QMin;
    return q_t'(s[DataW-1:0]);
  endfunction

  function automatic tl_ax_t tail_stage(input tl_op_e op, input tl_ax_t s,
                                        input logic [CfgW-1:0] dt,
                                        input logic [CfgW-1:0] wall,
                                        input logic signed [DampW:0] negd);
    tl_ax_t r;
    q_t     dt_s;
    q_t     wall_s;
    q_t     clamp;
    r      = s;
    dt_s   = $signed({1'b0, dt});
    wall_s = $signed({1'b0, wall});
    clamp  = '0;
    case (op)
      TlMulTmp:  r.prod = s.tmp * dt_s;
      TlShTmp:   r.tmp  = sat_shift(s.prod);
      TlAddVel:  r.vel  = sat_add(s.vel, s.tmp);
      TlMulVel:  r.prod = s.vel * dt_s;
      TlAddPos:  r.pos  = sat_add(s.pos, s.tmp);
      TlWall: begin
        r.hit1 = (s.pos > wall_s);
        clamp  = r.hit1 ? wall_s : s.pos;
        r.hit2 = clamp[DataW-1] || (clamp == '0);
        r.pos  = r.hit2 ? q_t'(0) : clamp;
      end
      TlMulDamp: r.prod = s.vel * negd;
      TlBounce1: r.vel  = s.hit1 ? sat_shift(s.prod) : s.vel;
      TlBounce2: r.vel  = s.hit2 ? sat_shift(s.prod) : s.vel;
      default:   r = s;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/particle_euler_integrate_bounce.sv
// ----------------------------------------------------------------------------
// particle_euler_integrate_bounce
// Semi-implicit Euler step with upper and lower wall bounce, 2D, Q16.16.
// ----------------------------------------------------------------------------
// One particle per s_axis transaction: position, velocity, force and mass.
// One m_axis transaction per particle: new position and velocity, in order.
// Acceleration comes from a 48-step restoring divider, one quotient bit per
// stage, one divider per axis sharing the mass. Twelve further stages do the
// two time-step products, the sums, the wall test and up to two damping
// products, each product registered before its shift and saturation.
// The pipeline takes one particle per cycle unless a receiver stall holds it.
// Registers (cfg_we_i, cfg_idx_i, cfg_data_i) must be written only while the
// block holds no particle; the block itself does not enforce this. Reset
// loads their default values and empties every stage.
// When the receiver stalls the pipeline freezes, but it still advances while
// its last stage is empty, so input is taken while a result waits.
`default_nettype none

`include "assert_macros.svh"

module particle_euler_integrate_bounce (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [peib_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [peib_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, push_x, push_y, particle_mass, zero pad
  input  wire logic [peib_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [peib_pkg::OutTdataW-1:0]       m_axis_tdata
);
  import peib_pkg::*;

  logic [CfgW-1:0]  dt_q;
  logic [CfgW-1:0]  wall_x_q;
  logic [CfgW-1:0]  wall_y_q;
  logic [DampW-1:0] damp_q;
  logic signed [DampW:0] negd;

  logic [Depth-1:0] vld_q;
  div_ax_t          dx_q [DivSteps+1];
  div_ax_t          dy_q [DivSteps+1];
  logic [CfgW-1:0]  mass_q [DivSteps];
  tl_ax_t           tx_q [TailStages];
  tl_ax_t           ty_q [TailStages];

  logic                 out_v_q;
  logic [OutTdataW-1:0] out_q;

  logic out_en;
  logic adv;
  logic in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= TimeStepRst;
      wall_x_q <= WallXRst;
      wall_y_q <= WallYRst;
      damp_q   <= DampRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegTimeStep: dt_q     <= cfg_data_i;
        RegWallX:    wall_x_q <= cfg_data_i;
        RegWallY:    wall_y_q <= cfg_data_i;
        RegDamping:  damp_q   <= cfg_data_i[DampW-1:0];
        default: ;
      endcase
    end
  end

  assign negd = -$signed({1'b0, damp_q});

  assign out_en        = !out_v_q || m_axis_tready;
  assign adv           = out_en || !vld_q[Depth-1];
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[Depth-2:0], in_acc};
      end
      if (out_en) begin
        out_v_q <= vld_q[Depth-1];
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[0]   <= div_load(q_t'(s_axis_tdata[31:0]), q_t'(s_axis_tdata[95:64]),
                            q_t'(s_axis_tdata[159:128]));
      dy_q[0]   <= div_load(q_t'(s_axis_tdata[63:32]), q_t'(s_axis_tdata[127:96]),
                            q_t'(s_axis_tdata[191:160]));
      mass_q[0] <= s_axis_tdata[222:192];
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dx_q[k] <= div_step(dx_q[k-1], mass_q[k-1]);
        dy_q[k] <= div_step(dy_q[k-1], mass_q[k-1]);
      end
    end
  end

  for (genvar k = 1; k < DivSteps; k++) begin : g_mass
    always_ff @(posedge clk_i) begin
      if (adv) begin
        mass_q[k] <= mass_q[k-1];
      end
    end
  end

  // acceleration out of the quotient
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q[0] <= '{pos: dx_q[DivSteps].pos, vel: dx_q[DivSteps].vel,
                   tmp: accel_of(dx_q[DivSteps]), prod: '0, hit1: 1'b0, hit2: 1'b0};
      ty_q[0] <= '{pos: dy_q[DivSteps].pos, vel: dy_q[DivSteps].vel,
                   tmp: accel_of(dy_q[DivSteps]), prod: '0, hit1: 1'b0, hit2: 1'b0};
    end
  end

  for (genvar k = 1; k < TailStages; k++) begin : g_tail
    always_ff @(posedge clk_i) begin
      if (adv) begin
        tx_q[k] <= tail_stage(TailOp[k], tx_q[k-1], dt_q, wall_x_q, negd);
        ty_q[k] <= tail_stage(TailOp[k], ty_q[k-1], dt_q, wall_y_q, negd);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= {ty_q[TailStages-1].vel, tx_q[TailStages-1].vel,
                ty_q[TailStages-1].pos, tx_q[TailStages-1].pos};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `ASSERT_AT(a_accept_enters, clk_i, rst_ni,
             (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                out_v_q && !m_axis_tready && s_axis_tready && vld_q[Depth-1])
  `ASSERT_AT(a_pos_x_in_box, clk_i, rst_ni,
             out_v_q |-> (!out_q[31] && (out_q[31:0] <= {1'b0, wall_x_q})))
  `ASSERT_AT(a_pos_y_in_box, clk_i, rst_ni,
             out_v_q |-> (!out_q[63] && (out_q[63:32] <= {1'b0, wall_y_q})))

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D particle Euler step with wall bounce.
// Streams particles through the block with random gaps and stalls on both
// sides, predicts every result in fixed point and compares it field by field.
// Runs several register settings, extremes included, and one long output
// hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import peib_pkg::*;

  localparam longint ONE          = 65536;
  localparam int     StallLimit   = 3000;
  localparam int     TailCycles   = 80;
  localparam int     RxHoldCycles = 300;

  // first field in the lowest bits
  typedef struct packed {
    logic [CfgW-1:0] mass;
    q_t push_y;
    q_t push_x;
    q_t vel_y;
    q_t vel_x;
    q_t pos_y;
    q_t pos_x;
  } particle_t;

  typedef struct packed {
    q_t vel_y;
    q_t vel_x;
    q_t pos_y;
    q_t pos_x;
  } motion_t;

  class motion_ledger;
    logic [CfgW-1:0]  step_q;
    logic [CfgW-1:0]  wall_x_q;
    logic [CfgW-1:0]  wall_y_q;
    logic [DampW-1:0] damp_q;
    motion_t          motion_due [$];
    int               failures;

    function new();
      step_q   = TimeStepRst;
      wall_x_q = WallXRst;
      wall_y_q = WallYRst;
      damp_q   = DampRst;
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
      case (idx)
        RegTimeStep: step_q   = val;
        RegWallX:    wall_x_q = val;
        RegWallY:    wall_y_q = val;
        RegDamping:  damp_q   = val[DampW-1:0];
        default:     ;
      endcase
    endfunction

    function int pending();
      return motion_due.size();
    endfunction

    static function longint clip32(longint v);
      if (v > longint'(QMax)) return longint'(QMax);
      if (v < longint'(QMin)) return longint'(QMin);
      return v;
    endfunction

    // floor(a * b / 2^16), saturated
    function longint scale_floor(longint a, longint b);
      longint p;
      p = a * b;
      return clip32(p >>> 16);
    endfunction

    function longint accel_from(longint f, longint m);
      if (m == 0) begin
        if (f > 0) return longint'(QMax);
        if (f < 0) return longint'(QMin);
        return 0;
      end
      return clip32((f * ONE) / m);
    endfunction

    function void advance_axis(inout longint p, inout longint v, input longint f,
                               input longint m, input longint wall);
      longint dt;
      longint negd;
      dt   = longint'(step_q);
      negd = -longint'(damp_q);
      v = clip32(v + scale_floor(accel_from(f, m), dt));
      p = clip32(p + scale_floor(v, dt));
      if (p > wall) begin
        p = wall;
        v = scale_floor(v, negd);
      end
      if (p <= 0) begin
        p = 0;
        v = scale_floor(v, negd);
      end
    endfunction

    function void note_particle(logic [InTdataW-1:0] raw);
      particle_t pt;
      motion_t   want;
      longint    px, py, vx, vy, m;
      pt = raw[$bits(particle_t)-1:0];
      px = pt.pos_x;
      py = pt.pos_y;
      vx = pt.vel_x;
      vy = pt.vel_y;
      m  = longint'(pt.mass);
      advance_axis(px, vx, pt.push_x, m, longint'(wall_x_q));
      advance_axis(py, vy, pt.push_y, m, longint'(wall_y_q));
      want.pos_x = q_t'(px);
      want.pos_y = q_t'(py);
      want.vel_x = q_t'(vx);
      want.vel_y = q_t'(vy);
      motion_due.push_back(want);
    endfunction

    function void check_motion(logic [OutTdataW-1:0] raw);
      motion_t got;
      motion_t want;
      q_t      w [4];
      q_t      g [4];
      string   field [4];
      got = raw;
      if (motion_due.size() == 0) begin
        $display("%0t: result with no particle pending, got %h", $time, raw);
        failures++;
        return;
      end
      want  = motion_due.pop_front();
      w     = '{want.pos_x, want.pos_y, want.vel_x, want.vel_y};
      g     = '{got.pos_x, got.pos_y, got.vel_x, got.vel_y};
      field = '{"new_pos_x", "new_pos_y", "new_vel_x", "new_vel_y"};
      for (int i = 0; i < 4; i++) begin
        if (w[i] !== g[i]) begin
          $display("%0t: %s expected %0d (%h) got %0d (%h)",
                   $time, field[i], w[i], w[i], g[i], g[i]);
          failures++;
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgW-1:0]      cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  motion_ledger ledger;
  bit           steady      = 1'b0;
  bit           hold_rx_req = 1'b0;

  particle_euler_integrate_bounce dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) ledger.note_particle(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) ledger.check_motion(m_axis_tdata);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : rx_side
    forever begin
      if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        repeat (RxHoldCycles) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
        @(negedge clk_i);
      end
    end
  end

  function automatic longint rand_between(longint lo, longint hi);
    return lo + (longint'({32'b0, $urandom()}) % (hi - lo + 1));
  endfunction

  function automatic longint pick_extreme(longint wall);
    case ($urandom_range(0, 6))
      0:       return longint'(QMin);
      1:       return longint'(QMax);
      2:       return 0;
      3:       return 1;
      4:       return -1;
      5:       return wall;
      default: return wall + 1;
    endcase
  endfunction

  function automatic longint pick_coord(longint wall);
    if ($urandom_range(0, 9) == 0) return pick_extreme(wall);
    return motion_ledger::clip32(rand_between(-64 * ONE, wall + 64 * ONE));
  endfunction

  function automatic longint pick_signed(longint span);
    case ($urandom_range(0, 19))
      0, 1:    return pick_extreme(0);
      2:       return longint'(q_t'($urandom()));
      default: return rand_between(-span, span);
    endcase
  endfunction

  function automatic longint pick_mass();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 8)  return 1;
    if (r < 11) return longint'(QMax);
    if (r < 20) return longint'({1'b0, $urandom()}) & longint'(QMax);
    return rand_between(ONE / 16, 64 * ONE);
  endfunction

  function automatic particle_t make_particle(longint px, longint py, longint vx, longint vy,
                                              longint fx, longint fy, longint m);
    particle_t p;
    p.pos_x  = q_t'(px);
    p.pos_y  = q_t'(py);
    p.vel_x  = q_t'(vx);
    p.vel_y  = q_t'(vy);
    p.push_x = q_t'(fx);
    p.push_y = q_t'(fy);
    p.mass   = CfgW'(m);
    return p;
  endfunction

  function automatic particle_t random_particle();
    particle_t           p;
    logic [InTdataW-1:0] raw;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom()};
      p   = raw[$bits(particle_t)-1:0];
    end else begin
      p = make_particle(pick_coord(ledger.wall_x_q), pick_coord(ledger.wall_y_q),
                        pick_signed(2000 * ONE), pick_signed(2000 * ONE),
                        pick_signed(500 * ONE), pick_signed(500 * ONE), pick_mass());
    end
    return p;
  endfunction

  // caller sits on a falling edge; returns on the falling edge after the transaction
  task automatic send_particle(input particle_t p);
    while (!steady && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_particle(random_particle());
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  task automatic load_regs(input longint dt, input longint wx, input longint wy,
                           input longint damp);
    cfg_reg_e        idx  [4];
    logic [CfgW-1:0] vals [4];
    idx  = '{RegTimeStep, RegWallX, RegWallY, RegDamping};
    vals = '{CfgW'(dt), CfgW'(wx), CfgW'(wy), CfgW'(damp)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= vals[i];
      ledger.set_reg(idx[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_regs();
    load_regs(rand_between(1, 2 * ONE), rand_between(ONE, 4000 * ONE),
              rand_between(ONE, 4000 * ONE), rand_between(0, ONE));
  endtask

  initial begin : stimulus
    longint wx;
    longint wy;
    ledger = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset register values
    wx = ledger.wall_x_q;
    wy = ledger.wall_y_q;
    send_particle(make_particle(0, 0, 0, 0, 0, 0, ONE));
    send_particle(make_particle(100 * ONE, 100 * ONE, 10 * ONE, -5 * ONE, ONE, 2 * ONE, ONE));
    send_particle(make_particle(900 * ONE, 700 * ONE, 50 * ONE, 50 * ONE, 0, 0, ONE));
    send_particle(make_particle(-5 * ONE, -1, -3 * ONE, -3, 0, 0, ONE));
    send_particle(make_particle(400 * ONE, 300 * ONE, 0, 0, 5 * ONE, -5 * ONE, 0));
    send_particle(make_particle(400 * ONE, 300 * ONE, 7 * ONE, -7 * ONE, 0, 0, 0));
    send_particle(make_particle(QMax, QMin, QMax, QMin, QMax, QMin, 1));
    send_particle(make_particle(QMin, QMax, QMin, QMax, QMin, QMax, QMax));
    send_particle(make_particle(wx, wy, 0, 0, 0, 0, ONE));
    send_particle(make_particle(wx + 1, wy + 1, -ONE, ONE, 0, 0, ONE));
    send_particle(make_particle(1, 1, -ONE, -ONE, 0, 0, ONE));
    send_particle(make_particle(200 * ONE, 200 * ONE, 0, 0, -1, 1, QMax));
    send_particle(make_particle(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                                32'hAAAAAAAA, 32'h55555555, 32'h2AAAAAAA));
    send_particle(make_particle(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                                32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    send_particle(make_particle(300 * ONE, 300 * ONE, 100 * ONE, -100 * ONE,
                                1000 * ONE, -1000 * ONE, 1));
    end_burst();

    // typical settings, a steady stretch, then an output hold-off under load
    load_random_regs();
    send_random(30);
    steady = 1'b1;
    send_random(60);
    steady = 1'b0;
    hold_rx_req = 1'b1;
    send_random(100);
    end_burst();

    // largest step, upper x wall at zero
    load_regs(longint'(QMax), 0, longint'(QMax), ONE);
    send_random(60);
    end_burst();

    // no motion, upper y wall at zero, no damping
    load_regs(0, longint'(QMax), 0, 0);
    send_random(50);
    end_burst();

    // unit step, narrow box, damping above one
    load_regs(ONE, 10 * ONE, 5 * ONE, (1 << DampW) - 1);
    send_random(60);
    end_burst();

    load_random_regs();
    send_random(120);
    end_burst();

    load_random_regs();
    send_random(30);
    end_burst();

    repeat (TailCycles) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
